// ===== sv/dws_pkg.sv =====
// Shared types and constants for the searchable double-ended queue.
package dws_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 5;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_BACK   = 2'd2,
		REQ_SEARCH     = 2'd3
	} req_e_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FOUND    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_e_t;

	// per-cell control, decoded once in the top level
	typedef struct packed {
		logic shift;      // take the left neighbour's word
		logic write_here; // load the request value (back insert lands here)
		logic occupied;   // cell lies below the fill level
		logic last;       // cell holds the back entry
	} cell_ctrl_t;

endpackage

// ===== sv/dws_cell.sv =====
// One storage cell of the queue chain: holds a word, shifts, compares.
module dws_cell (
	input  logic                        clk,
	input  dws_pkg::cell_ctrl_t         ctrl,
	input  logic signed [dws_pkg::DATA_W-1:0] prev_data,
	input  logic signed [dws_pkg::DATA_W-1:0] value,
	output logic signed [dws_pkg::DATA_W-1:0] data,
	output logic                        hit,
	output logic signed [dws_pkg::DATA_W-1:0] last_data
);
	import dws_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	// no reset: only words below the fill level are ever read
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= prev_data;
		end else if (ctrl.write_here) begin
			data_q <= value;
		end
	end

	assign data      = data_q;
	assign hit       = ctrl.occupied && (data_q == value);
	assign last_data = ctrl.last ? data_q : '0;

endmodule

// ===== sv/deque_with_search.sv =====
// Top level of the bounded double-ended queue with membership search.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  request | in_valid / in_ready    | req_type[1:0], value[31:0] signed
//  result  | out_valid / out_ready  | status[2:0], removed_value[31:0],
//          |                        | occupancy[4:0]
//
// Cycles: one request per cycle while in_ready is high; a request's result appears
//   in the output register on the cycle after the transfer.
// Reset: arst_n clears the fill level and the result-valid flag; cell words
//   are left as they are and never read before being written.
// Stalls: while a result waits and out_ready is low, in_ready drops; a
//   request is taken in the same cycle the waiting result leaves.
module deque_with_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        req_type,
	input  logic signed [dws_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic signed [dws_pkg::DATA_W-1:0] removed_value,
	output logic [dws_pkg::OCC_W-1:0]         occupancy
);
	import dws_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	status_e_t                 status_q;
	logic signed [DATA_W-1:0]  removed_q;
	logic [OCC_W-1:0]          occ_q;

	logic                      in_xfer;
	logic                      full;
	logic                      empty;
	req_e_t                    req;
	logic [CNT_W-1:0]          count_nxt;
	status_e_t                 status_nxt;
	logic signed [DATA_W-1:0]  removed_nxt;

	cell_ctrl_t                ctrl   [DEPTH];
	logic signed [DATA_W-1:0]  word   [DEPTH];
	logic signed [DATA_W-1:0]  lastw  [DEPTH];
	logic                      hit    [DEPTH];
	logic                      any_hit;
	logic signed [DATA_W-1:0]  back_word;

	// the output register frees up when its result transfers
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;
	assign req      = req_e_t'(req_type);
	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);

	// decode one control word per cell position
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].shift      = in_xfer && (req == REQ_PUSH_FRONT) && !full;
			ctrl[i].write_here = in_xfer && (req == REQ_PUSH_BACK) && !full
			                     && (count_q == CNT_W'(i));
			ctrl[i].occupied   = (CNT_W'(i) < count_q);
			ctrl[i].last       = (CNT_W'(i + 1) == count_q);
		end
	end

	// the chain: cell 0 takes the request value, every other cell its left neighbour
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dws_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[g]),
			.prev_data ((g == 0) ? value : word[(g == 0) ? 0 : g - 1]),
			.value     (value),
			.data      (word[g]),
			.hit       (hit[g]),
			.last_data (lastw[g])
		);
	end

	// gather the per-cell compare results and the back word
	always_comb begin
		any_hit   = 1'b0;
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			any_hit   = any_hit | hit[i];
			back_word = back_word | lastw[i];
		end
	end

	// result and next fill level
	always_comb begin
		count_nxt   = count_q;
		status_nxt  = ST_DONE;
		removed_nxt = '0;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt   = count_q - CNT_W'(1);
					removed_nxt = back_word;
				end
			end
			REQ_SEARCH: begin
				status_nxt = any_hit ? ST_FOUND : ST_NOTFOUND;
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: hold until the next request transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q  <= status_nxt;
			removed_q <= removed_nxt;
			occ_q     <= OCC_W'(count_nxt);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign occupancy     = occ_q;

	// fill level never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill level beyond capacity");

	// removal from an empty queue reports empty with a zero word
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (req == REQ_POP_BACK) && empty
		|=> (status == ST_EMPTY) && (removed_value == '0) && (count_q == '0))
		else $error("empty removal misreported");

	// search leaves the fill level alone and reports found or not found
	a_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (req == REQ_SEARCH)
		|=> (count_q == $past(count_q)) && (removed_value == '0)
		    && ((status == ST_FOUND) || (status == ST_NOTFOUND)))
		else $error("search result malformed");

	// a successful insert grows the queue by one and the result agrees
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && ((req == REQ_PUSH_FRONT) || (req == REQ_PUSH_BACK)) && !full
		|=> (count_q == $past(count_q) + CNT_W'(1)) && (status == ST_DONE)
		    && (occupancy == OCC_W'(count_q)))
		else $error("insert bookkeeping wrong");

endmodule
